// File: hdl/sacf_pkg.sv
package sacf_pkg;

  localparam int unsigned MaxLines  = 256;
  localparam int unsigned AddrBits  = 48;
  localparam int unsigned LineBits  = 8;
  localparam int unsigned CapLog2   = 8;
  localparam int unsigned MaxBlock  = 12;
  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] RegBlock  = 3'd0;
  localparam logic [2:0] RegSets   = 3'd1;
  localparam logic [2:0] RegWays   = 3'd2;
  localparam logic [2:0] RegPolicy = 3'd3;
  localparam logic [2:0] RegPrefch = 3'd4;

  localparam logic FuncRead  = 1'b0;
  localparam logic FuncWrite = 1'b1;
  localparam logic PolicyFifo = 1'b0;
  localparam logic PolicyLru  = 1'b1;

  typedef struct packed {
    logic                func;
    logic [AddrBits-1:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  mem_reads;
    logic        mem_write;
    logic        prefetch_filled;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_reads;
    logic [31:0] total_writes;
  } rsp_t;

  // effective geometry handed from the config block
  typedef struct packed {
    logic [3:0] blk;
    logic [3:0] sets;
    logic [3:0] ways;
    logic       lru;
    logic       pf_en;
  } geom_t;

  // classified access handed from front to back
  typedef struct packed {
    logic                is_write;
    logic [AddrBits-1:0] addr;
  } job_t;

endpackage

// File: hdl/sacf_ram.sv
module sacf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/sacf_front.sv
module sacf_front import sacf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output job_t q_data_o
);
  job_t       slot_q [QueueDepth];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = slot_q[rd_q];

  // store the classified access
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q].is_write <= (in_data_i.func == FuncWrite);
      slot_q[wr_q].addr     <= in_data_i.address;
    end
  end

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hdl/sacf_back.sv
module sacf_back import sacf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  geom_t geom_i,
  input  logic  q_valid_i,
  output logic  q_ready_o,
  input  job_t  q_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rsp_t  out_data_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StUpd   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]          st_q;
  logic                pf_phase_q;
  logic                is_wr_q;
  logic [AddrBits-1:0] addr_q, cur_q;
  logic [LineBits-1:0] base_q;
  logic [LineBits:0]   way_q;
  logic [AddrBits-1:0] tag_q;
  logic                found_q;
  logic [LineBits-1:0] fway_q;
  logic                free_q;
  logic [LineBits-1:0] freeway_q;
  logic [7:0]          maxr_q, hitr_q;
  logic [LineBits-1:0] maxway_q;
  logic                dhit_q;
  logic [MaxLines-1:0] valid_q;
  logic [LineBits-1:0] tgt_q;
  logic                tgt_valid_q;
  logic [LineBits:0]   ucnt_q;
  logic [31:0]         hits_q, miss_q, reads_q, writes_q;
  logic                obusy_q;
  rsp_t                out_q;

  logic [AddrBits-1:0] tag_rd;
  logic                tag_we;
  logic [7:0]          rank_rd, rank_wd;
  logic                rank_we;
  logic [LineBits-1:0] line_idx, raddr, sw_idx;
  logic [LineBits:0]   ways;
  logic [AddrBits-1:0] set_of, tag_of;

  assign ways = (LineBits+1)'(1) << geom_i.ways;
  assign set_of = (cur_q >> geom_i.blk) & ((AddrBits'(1) << geom_i.sets) - 1'b1);
  assign tag_of = cur_q >> ({1'b0, geom_i.blk} + {1'b0, geom_i.sets});
  assign line_idx = base_q + way_q[LineBits-1:0];
  assign sw_idx = LineBits'(ucnt_q - 1'b1) + base_q;

  // read address runs one step ahead of the way being examined
  always_comb begin
    case (st_q)
      StRead:  raddr = LineBits'(set_of << geom_i.ways);
      StUpd:   raddr = base_q + ucnt_q[LineBits-1:0];
      default: raddr = line_idx + LineBits'(1);
    endcase
  end

  assign tag_we = (st_q == StUpd) && !found_q && (ucnt_q == (LineBits+1)'(1));

  // age newer ways during the sweep, clear the rank of the target way
  assign rank_we = (st_q == StUpd) && (ucnt_q != '0) &&
                   ((sw_idx == tgt_q) ||
                    (valid_q[sw_idx] && (!tgt_valid_q || rank_rd < hitr_q)));
  assign rank_wd = (sw_idx == tgt_q) ? 8'd0 : rank_rd + 8'd1;

  sacf_ram #(.Width(AddrBits), .Depth(MaxLines)) u_tags (
    .clk_i, .we_i(tag_we), .waddr_i(tgt_q), .wdata_i(tag_q),
    .raddr_i(raddr), .rdata_o(tag_rd)
  );

  sacf_ram #(.Width(8), .Depth(MaxLines)) u_ranks (
    .clk_i, .we_i(rank_we), .waddr_i(sw_idx), .wdata_i(rank_wd),
    .raddr_i(raddr), .rdata_o(rank_rd)
  );

  assign q_ready_o  = (st_q == StIdle) && !obusy_q;
  assign out_valid_o = obusy_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      is_wr_q <= q_data_i.is_write;
      addr_q  <= q_data_i.addr;
      cur_q   <= q_data_i.addr;
    end else if (st_q == StDone && !pf_phase_q && !found_q && geom_i.pf_en) begin
      cur_q <= addr_q + (AddrBits'(1) << geom_i.blk);
    end
  end

  // walk ways one per cycle (tag and rank reads registered)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pf_phase_q <= 1'b0; obusy_q <= 1'b0;
      valid_q <= '0; hits_q <= '0; miss_q <= '0; reads_q <= '0; writes_q <= '0;
      way_q <= '0; base_q <= '0; ucnt_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
      dhit_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) obusy_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (q_valid_i && q_ready_o) begin
            st_q <= StRead; pf_phase_q <= 1'b0;
          end
        end
        StRead: begin
          base_q <= LineBits'(set_of << geom_i.ways);
          tag_q <= tag_of; way_q <= '0;
          found_q <= 1'b0; free_q <= 1'b0; maxr_q <= '0; maxway_q <= '0;
          st_q <= StScan;
        end
        StScan: begin
          // tag_rd and rank_rd are the entry at way_q
          if (!found_q && valid_q[line_idx] && tag_rd == tag_q) begin
            found_q <= 1'b1; fway_q <= line_idx; hitr_q <= rank_rd;
          end
          if (!free_q && !valid_q[line_idx]) begin
            free_q <= 1'b1; freeway_q <= line_idx;
          end
          if (rank_rd > maxr_q) begin
            maxr_q <= rank_rd; maxway_q <= line_idx;
          end
          if (way_q + 1'b1 == ways) begin
            st_q <= StUpd; ucnt_q <= '0;
          end else way_q <= way_q + 1'b1;
        end
        StUpd: begin
          // ucnt 0: choose target; then, unless a FIFO or prefetch hit ends here, sweep ways to adjust ranks
          if (ucnt_q == '0) begin
            if (found_q) begin
              tgt_q <= fway_q; tgt_valid_q <= 1'b1;
            end else if (free_q) begin
              tgt_q <= freeway_q; tgt_valid_q <= 1'b0;
            end else begin
              tgt_q <= (maxr_q == '0) ? base_q : maxway_q; tgt_valid_q <= 1'b1;
              hitr_q <= maxr_q;
            end
            if (free_q && !found_q) hitr_q <= '0;
            ucnt_q <= ucnt_q + 1'b1;
            if (found_q && (pf_phase_q || !geom_i.lru)) st_q <= StDone;
          end else begin
            if (ucnt_q == ways) begin
              valid_q[tgt_q] <= 1'b1; st_q <= StDone;
            end
            ucnt_q <= ucnt_q + 1'b1;
          end
        end
        StDone: begin
          if (!pf_phase_q) begin
            dhit_q <= found_q;
            if (!found_q && geom_i.pf_en) begin
              pf_phase_q <= 1'b1; st_q <= StRead;
            end else st_q <= StIdle;
          end else begin
            st_q <= StIdle;
          end
          if (!(!pf_phase_q && !found_q && geom_i.pf_en)) begin
            obusy_q <= 1'b1;
            begin
              logic dh, pfn;
              logic [1:0] rd;
              dh  = pf_phase_q ? dhit_q : found_q;
              pfn = pf_phase_q && !found_q;
              rd  = dh ? 2'd0 : (pfn ? 2'd2 : 2'd1);
              out_q.hit <= dh; out_q.mem_reads <= rd; out_q.mem_write <= is_wr_q;
              out_q.prefetch_filled <= pfn;
              out_q.total_hits   <= hits_q + {31'd0, dh};
              out_q.total_misses <= miss_q + {31'd0, !dh};
              out_q.total_reads  <= reads_q + {30'd0, rd};
              out_q.total_writes <= writes_q + {31'd0, is_wr_q};
              hits_q <= hits_q + {31'd0, dh}; miss_q <= miss_q + {31'd0, !dh};
              reads_q <= reads_q + {30'd0, rd}; writes_q <= writes_q + {31'd0, is_wr_q};
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: hdl/set_assoc_cache_fifo_lru_prefetch_unit.sv
// Flow: a queued access reads its set, scans the ways, then sweeps them to update ranks
//   for a fill or an LRU hit (a FIFO hit skips the sweep); a miss with prefetch adds a
//   second lookup of the next block, which skips the sweep when that block is present.
// Throughput: one access at a time in the back end, set by the one-way-per-cycle
//   tag RAM walk; a two-entry queue lets the front take accesses meanwhile.
// Reset: async active low; valid marks and counters clear at once; tag and rank
//   RAMs keep their contents and are read only behind a valid mark.
module set_assoc_cache_fifo_lru_prefetch_unit import sacf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [3:0] blk_q, sets_q, ways_q;
  logic       pol_q, pf_q;
  logic [2:0] idx;
  geom_t      geom;
  logic [3:0] eb, es, rest;
  logic       qv, qr;
  job_t       qd;

  assign pready = 1'b1;
  assign idx = paddr[CfgAddrW-1:2];

  // hold config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= 4'd6; sets_q <= '0; ways_q <= '0; pol_q <= PolicyFifo; pf_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegBlock:  blk_q  <= pwdata[3:0];
        RegSets:   sets_q <= pwdata[3:0];
        RegWays:   ways_q <= pwdata[3:0];
        RegPolicy: pol_q  <= pwdata[0];
        RegPrefch: pf_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegBlock:  prdata = {28'd0, blk_q};
      RegSets:   prdata = {28'd0, sets_q};
      RegWays:   prdata = {28'd0, ways_q};
      RegPolicy: prdata = {31'd0, pol_q};
      RegPrefch: prdata = {31'd0, pf_q};
      default:   prdata = '0;
    endcase
  end

  // clamp geometry
  assign eb = (blk_q > 4'(MaxBlock)) ? 4'(MaxBlock) : blk_q;
  assign es = (sets_q > 4'(CapLog2)) ? 4'(CapLog2) : sets_q;
  assign rest = 4'(CapLog2) - es;
  assign geom = '{blk: eb, sets: es, ways: (ways_q > rest) ? rest : ways_q,
                  lru: (pol_q == PolicyLru), pf_en: pf_q};

  sacf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  sacf_back u_back (
    .clk_i, .rst_ni, .geom_i(geom), .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hit ? out_data_o.mem_reads == 2'd0
                                    : out_data_o.mem_reads != 2'd0))
    else $error("read count disagrees with hit");
  a_pf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prefetch_filled |-> out_data_o.mem_reads == 2'd2)
    else $error("prefetch fill without second read");
endmodule

// File: tb/cache_checker.sv
`timescale 1ns / 1ps
module cache_checker import sacf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  req_t                in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rsp_t                out_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_val_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  rsp_count_o
);

  logic [AddrBits-1:0] tag_mem [MaxLines];
  logic                vld_mem [MaxLines];
  logic [7:0]          rank_mem[MaxLines];
  logic [31:0] hits_q, misses_q, reads_q, writes_q;
  logic [3:0] blk_q, sets_q, ways_q;
  logic       lru_q, pf_q;
  rsp_t       want_q[$];

  function automatic int unsigned blk_eff();
    return (blk_q > MaxBlock) ? MaxBlock : blk_q;
  endfunction

  function automatic int unsigned sets_eff();
    return (sets_q > CapLog2) ? CapLog2 : sets_q;
  endfunction

  function automatic int unsigned ways_eff();
    int unsigned rest;
    rest = CapLog2 - sets_eff();
    return (ways_q > rest) ? rest : ways_q;
  endfunction

  // make way w the newest; newer valid ways (all valid ways if w was invalid) age by one
  function automatic void make_newest(int unsigned base, int unsigned n, int unsigned w);
    logic was;
    int unsigned r;
    was = vld_mem[base + w];
    r = rank_mem[base + w];
    for (int unsigned i = 0; i < n; i++)
      if (i != w && vld_mem[base + i] && (!was || rank_mem[base + i] < r))
        rank_mem[base + i] = rank_mem[base + i] + 8'd1;
    rank_mem[base + w] = '0;
  endfunction

  // look up a block; fill on miss; return 1 on hit
  function automatic bit lookup_fill(logic [AddrBits-1:0] a, bit demand);
    int unsigned b, s, wl, n, base, victim, maxr;
    logic [AddrBits-1:0] set_idx, tag;
    b = blk_eff(); s = sets_eff(); wl = ways_eff();
    n = 1 << wl;
    set_idx = (a >> b) & ((48'd1 << s) - 1);
    tag = a >> (b + s);
    base = 32'(set_idx << wl);
    victim = n;
    maxr = 0;
    for (int unsigned i = 0; i < n; i++)
      if (vld_mem[base + i] && tag_mem[base + i] == tag) begin
        if (demand && lru_q == PolicyLru) make_newest(base, n, i);
        return 1'b1;
      end
    for (int unsigned i = 0; i < n; i++)
      if (victim == n && !vld_mem[base + i]) victim = i;
    if (victim == n) begin
      victim = 0;
      for (int unsigned i = 0; i < n; i++)
        if (rank_mem[base + i] > maxr) begin
          maxr = rank_mem[base + i];
          victim = i;
        end
    end
    make_newest(base, n, victim);
    tag_mem[base + victim] = tag;
    vld_mem[base + victim] = 1'b1;
    return 1'b0;
  endfunction

  function automatic rsp_t predict_access(req_t req);
    rsp_t r;
    logic [AddrBits-1:0] nxt;
    r = '0;
    r.hit = lookup_fill(req.address, 1'b1);
    if (r.hit) begin
      hits_q++;
    end else begin
      misses_q++;
      r.mem_reads = 2'd1;
      if (pf_q) begin
        nxt = req.address + (48'd1 << blk_eff());
        if (!lookup_fill(nxt, 1'b0)) begin
          r.prefetch_filled = 1'b1;
          r.mem_reads = 2'd2;
        end
      end
    end
    reads_q += r.mem_reads;
    if (req.func == FuncWrite) writes_q++;
    r.mem_write = (req.func == FuncWrite);
    r.total_hits = hits_q;
    r.total_misses = misses_q;
    r.total_reads = reads_q;
    r.total_writes = writes_q;
    return r;
  endfunction

  assign pending_o = want_q.size();

  // predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t w;
    if (!rst_ni) begin
      for (int i = 0; i < MaxLines; i++) begin
        vld_mem[i] = 1'b0;
        rank_mem[i] = '0;
      end
      hits_q = '0; misses_q = '0; reads_q = '0; writes_q = '0;
      blk_q = 4'd6; sets_q = '0; ways_q = '0; lru_q = PolicyFifo; pf_q = 1'b0;
      want_q.delete();
      fail_count_o = 0;
      rsp_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBlock:  blk_q = cfg_val_i[3:0];
          RegSets:   sets_q = cfg_val_i[3:0];
          RegWays:   ways_q = cfg_val_i[3:0];
          RegPolicy: lru_q = cfg_val_i[0];
          RegPrefch: pf_q = cfg_val_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        rsp_count_o++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          w = want_q.pop_front();
          if (w !== out_data_i) begin
            $display("%0t: mismatch expected %h actual %h", $time, w, out_data_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) want_q.push_back(predict_access(in_data_i));
    end
  end

endmodule

// File: tb/tb_set_assoc_cache_fifo_lru_prefetch_unit.sv
`timescale 1ns / 1ps
module tb_set_assoc_cache_fifo_lru_prefetch_unit;
  import sacf_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  req_t in_data_i;
  rsp_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fails, pending, rsp_count, items_sent;
  int idle_cycles = 0;
  int idle_pct;
  bit hold_req;
  bit cfg_we;

  set_assoc_cache_fifo_lru_prefetch_unit dut (.*);

  assign cfg_we = psel && penable && pwrite && pready;

  cache_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i(cfg_we), .cfg_idx_i(paddr[4:2]), .cfg_val_i(pwdata),
    .fail_count_o(fails), .pending_o(pending), .rsp_count_o(rsp_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int left;
    bit held;
    left = 0;
    held = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        left = 300;
        held = 1'b1;
      end
      if (left > 0) begin
        out_ready_i <= 1'b0;
        left = left - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one access; valid stays high into the next one unless idling
  task automatic send_access(logic f, logic [AddrBits-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{func: f, address: a};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // random accesses clustered on a few blocks so hits and evictions occur
  task automatic random_phase(int n);
    logic [AddrBits-1:0] base_addr, a;
    base_addr = AddrBits'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: a = AddrBits'({$urandom, $urandom});
        default: a = base_addr + ($urandom_range(31) << $urandom_range(12))
                     + $urandom_range(63);
      endcase
      send_access(1'($urandom_range(1)), a);
    end
  endtask

  task automatic set_geom(int b, int s, int w, int p, int f);
    cfg_write(RegBlock, b);
    cfg_write(RegSets, s);
    cfg_write(RegWays, w);
    cfg_write(RegPolicy, p);
    cfg_write(RegPrefch, f);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    items_sent = 0; idle_pct = 27;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, both funcs, wrapping prefetch, reset geometry
    send_access(FuncRead, '0);
    send_access(FuncWrite, '0);
    send_access(FuncWrite, '1);
    send_access(FuncRead, 48'h0000_0000_0040);
    drain();
    set_geom(0, 2, 1, 1, 1);
    send_access(FuncRead, '1);
    send_access(FuncRead, '0);
    send_access(FuncWrite, 48'h1);
    send_access(FuncRead, 48'h8);
    send_access(FuncRead, 48'h10);
    send_access(FuncRead, 48'h0);
    send_access(FuncWrite, 48'hAAAA_AAAA_AAAA);
    send_access(FuncWrite, 48'h5555_5555_5555);
    drain();
    // saturating values beyond capacity and block limit, then an all-ones write to an unmapped register
    set_geom(15, 15, 15, 1, 1);
    send_access(FuncRead, 48'hFFFF_FFFF_F000);
    send_access(FuncRead, 48'h0000_0000_1000);
    send_access(FuncRead, 48'hFFFF_FFFF_F000);
    drain();
    cfg_write(3'd5, 32'hFFFF_FFFF);

    // random phases over several geometries and both policies
    set_geom(4, 1, 2, 0, 0); random_phase(100); drain();
    set_geom(6, 0, 8, 1, 1); random_phase(100); drain();
    set_geom(12, 8, 0, 0, 1); random_phase(80); drain();
    set_geom(2, 3, 3, 1, 0);
    // long receiver hold-off so the block fills and stalls
    hold_req = 1'b1;
    random_phase(60);
    drain();
    set_geom(3, 2, 4, 0, 1);
    idle_pct = 0;
    random_phase(140);
    idle_pct = 27;
    drain();
    set_geom(5, 4, 2, 1, 1); random_phase(155);
    drain();

    $display("Covered %0d accesses, %0d results, FIFO and LRU, prefetch on and off,",
             items_sent, rsp_count);
    $display("geometries from one way to full associativity incl. saturated settings.");
    if (fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
